### rtl/text_console_writer_assert.svh
// ----------------------------------------------------------------------------
// text console writer assertion macros
// concurrent checks, disabled while the active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define TCW_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds in this cycle, consequent in the next cycle
`define TCW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// field widths, codes and shared types of the text console writer
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    // payload field widths
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // control characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK     = 8'h20;

    // attribute after reset
    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'h0F;

    // one result word
    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] read_cell;
    } t_res;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_READ   = 4'b0010,
        ST_SCROLL = 4'b0100,
        ST_FILL   = 4'b1000
    } t_state;

endpackage

`default_nettype wire

### rtl/tcw_in_if.sv
// ----------------------------------------------------------------------------
// tcw_in_if
// item channel of the text console writer: valid, ready and request fields
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_in_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;

    modport source (output valid, output op, output char_code, output cell_index,
                    input ready);
    modport sink   (input valid, input op, input char_code, input cell_index,
                    output ready);
endinterface

`default_nettype wire

### rtl/tcw_out_if.sv
// ----------------------------------------------------------------------------
// tcw_out_if
// result channel of the text console writer: valid, ready and result fields
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_out_if;
    import tcw_pkg::*;

    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [POS_W-1:0]  cursor_pos;
    logic [CELL_W-1:0] read_cell;

    modport source (output valid, output cursor_col, output cursor_row,
                    output cursor_pos, output read_cell, input ready);
    modport sink   (input valid, input cursor_col, input cursor_row,
                    input cursor_pos, input read_cell, output ready);
endinterface

`default_nettype wire

### rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// character-cell text console with screen memory and cursor
//
// i_in carries one item per word: op put, clear or read, with char_code and
// cell_index; o_out returns one word per item with the cursor column, row and
// linear position after the item, and the cell word for a read (else zero).
// i_cfg_we with i_cfg_wdata sets the attribute byte of written cells.
// A put that does not scroll keeps the sequencer in ST_IDLE, and its result
// passes the staging and output registers; a read waits in ST_READ for the
// registered ram read. A put or newline that leaves the last row scrolls the
// screen: ST_SCROLL moves each cell below the top row up one row, then ST_FILL
// blanks the bottom row. A clear sweeps all COLUMNS*ROWS cells, one a cycle.
// After reset the same sweep writes blank cells with attribute 0x0F; no item
// is taken until the sweep ends, configuration writes are.
// A staging register and the output register hold up to two results; when
// the receiver stalls, items are taken until both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [tcw_pkg::ATTR_W-1:0] i_cfg_wdata,
    tcw_in_if.sink                         i_in,
    tcw_out_if.source                      o_out
);
    import tcw_pkg::*;

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CLW   = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    localparam logic [CLW-1:0] LAST_COL  = CLW'(COLUMNS - 1);
    localparam logic [RW-1:0]  LAST_ROW  = RW'(ROWS - 1);
    localparam logic [AW-1:0]  LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0]  BOT_ROW   = AW'((ROWS - 1) * COLUMNS);
    localparam logic [AW-1:0]  COL_STEP  = AW'(COLUMNS);
    localparam logic [CELL_W-1:0] RESET_WORD = {RESET_ATTR, CH_BLANK};

    // registers
    t_state              r_state, n_state;
    logic [AW-1:0]       r_addr, n_addr;
    logic [CLW-1:0]      r_col, n_col;
    logic [RW-1:0]       r_row, n_row;
    logic [AW-1:0]       r_pos, n_pos;
    logic [CELL_W-1:0]   r_fill_word, n_fill_word;
    logic                r_fill_res, n_fill_res;
    logic                r_rd_ok, n_rd_ok;
    t_res                r_res, n_res;
    logic                r_res_valid, n_res_valid;
    t_res                r_out, n_out;
    logic                r_out_valid, n_out_valid;
    logic [ATTR_W-1:0]   r_attr;

    // ram port signals
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    logic                in_fire;
    logic                res_move;
    logic                wrap;
    logic [CELL_W-1:0]   blank_word;

    assign blank_word = {r_attr, CH_BLANK};
    assign res_move   = r_res_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = (r_state == ST_IDLE) && (!r_res_valid || res_move);
    assign in_fire    = i_in.valid && i_in.ready;

    // screen memory
    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer, cursor update and memory access
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_col       = r_col;
        n_row       = r_row;
        n_pos       = r_pos;
        n_fill_word = r_fill_word;
        n_fill_res  = r_fill_res;
        n_rd_ok     = r_rd_ok;
        n_res       = r_res;
        n_res_valid = r_res_valid && !res_move;
        ram_we      = 1'b0;
        ram_waddr   = r_addr;
        ram_wdata   = r_fill_word;
        ram_re      = 1'b0;
        ram_raddr   = r_addr + COL_STEP;
        wrap        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    case (i_in.op)
                        OP_PUT: begin
                            case (i_in.char_code)
                                CH_NEWLINE: begin
                                    wrap = 1'b1;
                                end
                                CH_BACKSPACE: begin
                                    // blank the previous cell, back over a row edge
                                    if (r_pos != '0) begin
                                        ram_we    = 1'b1;
                                        ram_waddr = r_pos - AW'(1);
                                        ram_wdata = blank_word;
                                        n_pos     = r_pos - AW'(1);
                                        if (r_col != '0) begin
                                            n_col = r_col - CLW'(1);
                                        end else begin
                                            n_col = LAST_COL;
                                            n_row = r_row - RW'(1);
                                        end
                                    end
                                end
                                CH_RETURN: begin
                                    n_col = '0;
                                    n_pos = r_pos - AW'(r_col);
                                end
                                default: begin
                                    // printable byte at the cursor
                                    ram_we    = 1'b1;
                                    ram_waddr = r_pos;
                                    ram_wdata = {r_attr, i_in.char_code};
                                    if (r_col == LAST_COL) begin
                                        wrap = 1'b1;
                                    end else begin
                                        n_col = r_col + CLW'(1);
                                        n_pos = r_pos + AW'(1);
                                    end
                                end
                            endcase
                            // next row, scrolling from the bottom row
                            if (wrap) begin
                                n_col = '0;
                                if (r_row == LAST_ROW) begin
                                    n_pos   = BOT_ROW;
                                    n_addr  = '0;
                                    n_state = ST_SCROLL;
                                end else begin
                                    n_row = r_row + RW'(1);
                                    n_pos = r_pos - AW'(r_col) + COL_STEP;
                                end
                            end
                            n_res_valid = !(wrap && (r_row == LAST_ROW));
                        end
                        OP_CLEAR: begin
                            n_col       = '0;
                            n_row       = '0;
                            n_pos       = '0;
                            n_addr      = '0;
                            n_fill_word = blank_word;
                            n_fill_res  = 1'b1;
                            n_state     = ST_FILL;
                            n_res_valid = 1'b0;
                        end
                        OP_READ: begin
                            ram_re      = 1'b1;
                            ram_raddr   = AW'(i_in.cell_index);
                            n_rd_ok     = 32'(i_in.cell_index) < 32'(CELLS);
                            n_state     = ST_READ;
                            n_res_valid = 1'b0;
                        end
                        default: begin
                            n_res_valid = 1'b1;
                        end
                    endcase
                    n_res.cursor_col = COL_W'(n_col);
                    n_res.cursor_row = ROW_W'(n_row);
                    n_res.cursor_pos = POS_W'(n_pos);
                    n_res.read_cell  = '0;
                end
            end
            ST_READ: begin
                n_res.read_cell = r_rd_ok ? ram_rdata : '0;
                n_res_valid     = 1'b1;
                n_state         = ST_IDLE;
            end
            ST_SCROLL: begin
                // read one row down, write back the word that the previous read returned
                ram_re    = (r_addr != BOT_ROW);
                ram_raddr = r_addr + COL_STEP;
                ram_we    = (r_addr != '0);
                ram_waddr = r_addr - AW'(1);
                ram_wdata = ram_rdata;
                if (r_addr == BOT_ROW) begin
                    n_fill_word = blank_word;
                    n_fill_res  = 1'b1;
                    n_state     = ST_FILL;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            ST_FILL: begin
                // blank cells from r_addr to the end of the screen
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = r_fill_word;
                if (r_addr == LAST_CELL) begin
                    n_state = ST_IDLE;
                    if (r_fill_res) begin
                        n_res_valid = 1'b1;
                    end
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_out.ready;
        if (res_move) begin
            n_out       = r_res;
            n_out_valid = 1'b1;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_addr      <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_pos       <= '0;
            r_fill_word <= RESET_WORD;
            r_fill_res  <= 1'b0;
            r_res_valid <= 1'b0;
            r_out_valid <= 1'b0;
            r_attr      <= RESET_ATTR;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_col       <= n_col;
            r_row       <= n_row;
            r_pos       <= n_pos;
            r_fill_word <= n_fill_word;
            r_fill_res  <= n_fill_res;
            r_res_valid <= n_res_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_ok <= n_rd_ok;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // result channel
    assign o_out.valid      = r_out_valid;
    assign o_out.cursor_col = r_out.cursor_col;
    assign o_out.cursor_row = r_out.cursor_row;
    assign o_out.cursor_pos = r_out.cursor_pos;
    assign o_out.read_cell  = r_out.read_cell;

    // checks
    `include "text_console_writer_assert.svh"

    `TCW_ASSERT_SAME(a_cursor_range, i_clk, i_rst_n, 1'b1,
        (32'(r_col) < 32'(COLUMNS)) && (32'(r_row) < 32'(ROWS)),
        "cursor outside the screen")
    `TCW_ASSERT_SAME(a_pos_match, i_clk, i_rst_n, 1'b1,
        32'(r_pos) == 32'(r_row) * 32'(COLUMNS) + 32'(r_col),
        "linear cursor position out of step with column and row")
    `TCW_ASSERT_NEXT(a_res_held, i_clk, i_rst_n, r_res_valid && !res_move,
        r_res_valid && $stable(r_res), "staged result lost or overwritten")
    `TCW_ASSERT_NEXT(a_read_seq, i_clk, i_rst_n, in_fire && (i_in.op == OP_READ),
        r_state == ST_READ, "read item did not wait for the memory")

endmodule

`default_nettype wire

### rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// simple dual-port ram, one write and one registered read port, read-first
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire
